[sv/cca_pkg.sv]
// Shared constants, register and mode codes, and small arithmetic helpers
// for the cyclic cellular automaton grid. No dependencies.
package cca_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_STATE_BITS = 4;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 7;

	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_STATES  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_EDGES  = 3'd4;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_STEP  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [4:0] NUM_STATES_MIN = 5'd3;
	localparam logic [4:0] NUM_STATES_MAX = 5'd16;
	localparam logic [3:0] THRESHOLD_MIN  = 4'd1;
	localparam logic [3:0] THRESHOLD_MAX  = 4'd8;
	localparam logic [4:0] NUM_STATES_RST = 5'd8;
	localparam logic [3:0] THRESHOLD_RST  = 4'd3;

	localparam logic [15:0] LEVEL_FULL = 16'hFFFF;

	// 65535 split by divisor d: quotient and remainder
	localparam logic [15:0] LVL_Q [16] = '{16'd0, 16'd65535, 16'(65535/2), 16'(65535/3),
		16'(65535/4), 16'(65535/5), 16'(65535/6), 16'(65535/7), 16'(65535/8),
		16'(65535/9), 16'(65535/10), 16'(65535/11), 16'(65535/12), 16'(65535/13),
		16'(65535/14), 16'(65535/15)};
	localparam logic [3:0] LVL_R [16] = '{4'd0, 4'd0, 4'(65535%2), 4'(65535%3),
		4'(65535%4), 4'(65535%5), 4'(65535%6), 4'(65535%7), 4'(65535%8),
		4'(65535%9), 4'(65535%10), 4'(65535%11), 4'(65535%12), 4'(65535%13),
		4'(65535%14), 4'(65535%15)};

	// v mod ns for v <= 16 and ns >= 3: at most five subtractions
	function automatic logic [4:0] mod_small(input logic [4:0] v, input logic [4:0] ns);
		logic [4:0] r;
		r = v;
		for (int i = 0; i < 5; i++) begin
			if (r >= ns) begin
				r = r - ns;
			end
		end
		return r;
	endfunction

	// s*65535/(ns-1), saturated
	function automatic logic [15:0] level_of(input logic [3:0] s, input logic [4:0] ns);
		logic [3:0]  d;
		logic [8:0]  rem;
		logic [3:0]  q;
		logic [19:0] base;
		d = 4'(ns - 5'd1);
		rem = 9'(s * LVL_R[d]);
		q = '0;
		for (int i = 3; i >= 0; i--) begin
			if (rem >= (9'(d) << i)) begin
				rem = rem - (9'(d) << i);
				q[i] = 1'b1;
			end
		end
		base = 20'(s) * 20'(LVL_Q[d]);
		if (s >= d) begin
			return LEVEL_FULL;
		end
		return 16'(base + 20'(q));
	endfunction

endpackage

[sv/cca_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cca_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/cyclic_cellular_automaton_grid_top.sv]
// Cyclic cellular automaton grid: two cell banks, write/read/step requests.
// Depends on cca_pkg and cca_ram.
// Write and read: one request per cycle unless the output stalls; each result is
// registered in stage one, then in the output. Step: nine single-port bank reads per
// cell over all MAX_WIDTH*MAX_HEIGHT cells, then a bank swap and result; input held off.
// Reset clears control and bank select and loads register defaults; banks undefined.
module cyclic_cellular_automaton_grid_top #(
	parameter int MAX_WIDTH  = cca_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cca_pkg::DEF_MAX_HEIGHT,
	parameter int STATE_BITS = cca_pkg::DEF_STATE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [23:0]                       s_axis_tdata,  // mode, col, row, load_state
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata,  // read_state, level, grid_changed
	input  logic                              cfg_wr_en,
	input  logic [cca_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [cca_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int GB0   = (XW > YW ? XW : YW) + 1;
	localparam int GB    = GB0 > 7 ? GB0 : 7;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [1:0] OFS_SAME = 2'd0;
	localparam logic [1:0] OFS_DEC  = 2'd1;
	localparam logic [1:0] OFS_INC  = 2'd2;

	// configuration
	logic [4:0]    ns_q;
	logic [3:0]    thr_q;
	logic [GB-1:0] gw_q, gh_q;
	logic          wrap_q;
	logic [GB-1:0] cfg_ext;

	assign cfg_ext = GB'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_q   <= cca_pkg::NUM_STATES_RST;
			thr_q  <= cca_pkg::THRESHOLD_RST;
			gw_q   <= GB'(MAX_WIDTH < 64 ? MAX_WIDTH : 64);
			gh_q   <= GB'(MAX_HEIGHT < 64 ? MAX_HEIGHT : 64);
			wrap_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cca_pkg::REG_NUM_STATES: begin
					if (cfg_data[4:0] < cca_pkg::NUM_STATES_MIN) ns_q <= cca_pkg::NUM_STATES_MIN;
					else if (cfg_data[4:0] > cca_pkg::NUM_STATES_MAX) ns_q <= cca_pkg::NUM_STATES_MAX;
					else ns_q <= cfg_data[4:0];
				end
				cca_pkg::REG_THRESHOLD: begin
					if (cfg_data[3:0] < cca_pkg::THRESHOLD_MIN) thr_q <= cca_pkg::THRESHOLD_MIN;
					else if (cfg_data[3:0] > cca_pkg::THRESHOLD_MAX) thr_q <= cca_pkg::THRESHOLD_MAX;
					else thr_q <= cfg_data[3:0];
				end
				cca_pkg::REG_GRID_WIDTH: begin
					if (cfg_ext == '0) gw_q <= GB'(1);
					else if (cfg_ext > GB'(MAX_WIDTH)) gw_q <= GB'(MAX_WIDTH);
					else gw_q <= cfg_ext;
				end
				cca_pkg::REG_GRID_HEIGHT: begin
					if (cfg_ext == '0) gh_q <= GB'(1);
					else if (cfg_ext > GB'(MAX_HEIGHT)) gh_q <= GB'(MAX_HEIGHT);
					else gh_q <= cfg_ext;
				end
				cca_pkg::REG_WRAP_EDGES: wrap_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [1:0] in_mode;
	logic [5:0] in_col, in_row;
	logic [3:0] in_load;
	logic       in_inside;
	logic [AW-1:0] in_addr;
	logic [STATE_BITS-1:0] in_wval;

	assign in_mode   = s_axis_tdata[1:0];
	assign in_col    = s_axis_tdata[7:2];
	assign in_row    = s_axis_tdata[13:8];
	assign in_load   = s_axis_tdata[17:14];
	assign in_inside = (GB'(in_col) < gw_q) && (GB'(in_row) < gh_q);
	assign in_addr   = AW'(AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col));
	assign in_wval   = STATE_BITS'(cca_pkg::mod_small(5'(in_load), ns_q));

	logic [1:0] state_q;
	logic       bank_sel_q;
	logic       accept;
	logic       v_s1, adv_s1;
	logic [1:0] mode_s1;
	logic       inside_s1;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign adv_s1        = v_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = (state_q == ST_IDLE) && (!v_s1 || adv_s1);

	// sweep counters and neighbour address
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [3:0]    k_q;
	logic          issue;
	logic          x_last, y_last;
	logic [XW-1:0] nx;
	logic [YW-1:0] ny;
	logic          xpres, ypres;
	logic [1:0]    dxs, dys;
	logic          cell_in;
	logic [AW-1:0] cell_addr, nb_addr;

	assign issue  = (state_q == ST_SWEEP) && !v_s1;
	assign x_last = x_q == XW'(MAX_WIDTH - 1);
	assign y_last = y_q == YW'(MAX_HEIGHT - 1);
	assign cell_in = (GB'(x_q) < gw_q) && (GB'(y_q) < gh_q);
	assign cell_addr = AW'(AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q));

	always_comb begin
		case (k_q)
			4'd1:    begin dxs = OFS_DEC;  dys = OFS_DEC;  end
			4'd2:    begin dxs = OFS_SAME; dys = OFS_DEC;  end
			4'd3:    begin dxs = OFS_INC;  dys = OFS_DEC;  end
			4'd4:    begin dxs = OFS_DEC;  dys = OFS_SAME; end
			4'd5:    begin dxs = OFS_INC;  dys = OFS_SAME; end
			4'd6:    begin dxs = OFS_DEC;  dys = OFS_INC;  end
			4'd7:    begin dxs = OFS_SAME; dys = OFS_INC;  end
			4'd8:    begin dxs = OFS_INC;  dys = OFS_INC;  end
			default: begin dxs = OFS_SAME; dys = OFS_SAME; end
		endcase
		nx = x_q;
		xpres = 1'b1;
		if (dxs == OFS_DEC) begin
			if (x_q == '0) begin
				nx = XW'(gw_q - GB'(1));
				xpres = wrap_q;
			end else begin
				nx = x_q - XW'(1);
			end
		end else if (dxs == OFS_INC) begin
			if (GB'(x_q) + GB'(1) >= gw_q) begin
				nx = '0;
				xpres = wrap_q;
			end else begin
				nx = x_q + XW'(1);
			end
		end
		ny = y_q;
		ypres = 1'b1;
		if (dys == OFS_DEC) begin
			if (y_q == '0) begin
				ny = YW'(gh_q - GB'(1));
				ypres = wrap_q;
			end else begin
				ny = y_q - YW'(1);
			end
		end else if (dys == OFS_INC) begin
			if (GB'(y_q) + GB'(1) >= gh_q) begin
				ny = '0;
				ypres = wrap_q;
			end else begin
				ny = y_q + YW'(1);
			end
		end
	end

	assign nb_addr = AW'(AW'(ny) * AW'(MAX_WIDTH) + AW'(nx));

	// sweep stage one tags
	logic          sv_s1, pres_s1, ing_s1;
	logic [3:0]    k_s1;
	logic [AW-1:0] caddr_s1;
	logic [STATE_BITS-1:0] self_q, succ_q;
	logic [3:0]    cnt_q;
	logic [3:0]    cnt_total;
	logic          changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bank_sel_q <= 1'b0;
			x_q        <= '0;
			y_q        <= '0;
			k_q        <= '0;
			sv_s1      <= 1'b0;
			changed_q  <= 1'b0;
		end else begin
			sv_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_mode == cca_pkg::MODE_STEP) begin
						state_q   <= ST_SWEEP;
						x_q       <= '0;
						y_q       <= '0;
						k_q       <= '0;
						changed_q <= 1'b0;
					end
				end
				ST_SWEEP: begin
					if (issue) begin
						if (k_q == 4'd8) begin
							k_q <= '0;
							if (x_last) begin
								x_q <= '0;
								y_q <= y_q + YW'(1);
								if (y_last) begin
									state_q <= ST_DRAIN;
								end
							end else begin
								x_q <= x_q + XW'(1);
							end
						end else begin
							k_q <= k_q + 4'd1;
						end
					end
				end
				ST_DRAIN: begin
					// last cell is written at this edge; swap banks
					bank_sel_q <= !bank_sel_q;
					state_q    <= ST_FIN;
				end
				ST_FIN: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (sv_s1 && k_s1 == 4'd8 && ing_s1 && cnt_total >= thr_q) begin
				changed_q <= 1'b1;
			end
		end
	end

	// banks
	logic [STATE_BITS-1:0] rd_a, rd_b, rd_data;
	logic                  re;
	logic [AW-1:0]         raddr, waddr;
	logic                  in_we, sw_we, we_a, we_b;
	logic [STATE_BITS-1:0] wdata, newv;
	logic                  match;

	assign re      = accept || issue;
	assign raddr   = issue ? ((k_q == '0) ? cell_addr : nb_addr) : in_addr;
	assign rd_data = bank_sel_q ? rd_b : rd_a;
	assign match   = pres_s1 && (rd_data == succ_q);
	assign cnt_total = cnt_q + 4'(match);
	assign newv    = (ing_s1 && cnt_total >= thr_q) ? succ_q : self_q;
	assign in_we   = accept && in_mode == cca_pkg::MODE_WRITE && in_inside;
	assign sw_we   = sv_s1 && k_s1 == 4'd8;
	assign waddr   = sw_we ? caddr_s1 : in_addr;
	assign wdata   = sw_we ? newv : in_wval;
	assign we_a    = (in_we && !bank_sel_q) || (sw_we && bank_sel_q);
	assign we_b    = (in_we && bank_sel_q) || (sw_we && !bank_sel_q);

	cca_ram #(.WIDTH(STATE_BITS), .DEPTH(CELLS)) u_bank_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rd_a)
	);

	cca_ram #(.WIDTH(STATE_BITS), .DEPTH(CELLS)) u_bank_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rd_b)
	);

	always_ff @(posedge clk) begin
		if (issue) begin
			k_s1     <= k_q;
			pres_s1  <= xpres && ypres;
			ing_s1   <= cell_in;
			caddr_s1 <= cell_addr;
		end
		if (sv_s1) begin
			if (k_s1 == '0) begin
				self_q <= rd_data;
				succ_q <= STATE_BITS'(cca_pkg::mod_small(5'(rd_data) + 5'd1, ns_q));
				cnt_q  <= '0;
			end else begin
				cnt_q <= cnt_total;
			end
		end
	end

	// request stage one and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (accept && in_mode != cca_pkg::MODE_STEP) v_s1 <= 1'b1;
			else if (adv_s1) v_s1 <= 1'b0;
			if (adv_s1 || (state_q == ST_FIN && (!m_axis_tvalid || m_axis_tready))) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	logic [3:0]  rs;
	logic [23:0] rd_resp, step_resp;
	assign rs = 4'(rd_data);

	always_comb begin
		rd_resp = '0;
		if (mode_s1 == cca_pkg::MODE_READ && inside_s1) begin
			rd_resp[3:0]  = rs;
			rd_resp[19:4] = cca_pkg::level_of(rs, ns_q);
		end
		step_resp     = '0;
		step_resp[20] = changed_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= in_mode;
			inside_s1 <= in_inside;
		end
		if (adv_s1) begin
			m_axis_tdata <= rd_resp;
		end else if (state_q == ST_FIN && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tdata <= step_resp;
		end
	end

endmodule
